// ----- src/gld_pkg.sv -----
`default_nettype none
package gld_pkg;

  localparam logic [1:0] KIND_START = 2'd0;
  localparam logic [1:0] KIND_PUSH  = 2'd1;
  localparam logic [1:0] KIND_PULL  = 2'd2;

  localparam logic [2:0] ST_PIXEL    = 3'd0;
  localparam logic [2:0] ST_ACCEPT   = 3'd1;
  localparam logic [2:0] ST_REJECT   = 3'd2;
  localparam logic [2:0] ST_STARVED  = 3'd3;
  localparam logic [2:0] ST_END      = 3'd4;
  localparam logic [2:0] ST_RANOUT   = 3'd5;
  localparam logic [2:0] ST_CIRCULAR = 3'd6;

  localparam logic [3:0] MIN_CODE_RESET = 4'd8;
  localparam logic [3:0] ROOT_MIN       = 4'd2;
  localparam logic [3:0] ROOT_MAX       = 4'd8;

  localparam logic [2:0] REG_MIN_CODE_ADDR = 3'd0;

  typedef struct packed {
    logic [1:0] kind;
    logic [7:0] data_byte;
  } in_word_t;

  typedef struct packed {
    logic [2:0] status;
    logic [7:0] pixel;
  } out_word_t;

endpackage
`default_nettype wire

// ----- src/gif_lzw_decoder_core.sv -----
// start, push and unused words: result in the cycle after the word is taken
// pull with a pending stacked pixel: result read from the stack memory in S_STK
// pull that decodes: S_QLD moves each queued byte into the bit buffer, and S_WALK
// and S_WRD read each chain link from the code table memory; one word in flight
// reset: control state cleared and an image started with min code size 8; the memories
// get no clearing pass, entries outside the live code range read as zero
`default_nettype none
module gif_lzw_decoder_core import gld_pkg::*; #(
  parameter int MAX_CODE_BITS = 12,
  parameter int QUEUE_DEPTH   = 16
) (
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire logic      in_valid_i,
  output logic           in_ready_o,
  input  wire in_word_t  in_data_i,
  output logic           out_valid_o,
  input  wire logic      out_ready_i,
  output out_word_t      out_data_o,
  input  wire logic      psel,
  input  wire logic      penable,
  input  wire logic      pwrite,
  input  wire logic [2:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]    prdata,
  output logic           pready
);

  localparam int CW  = MAX_CODE_BITS;
  localparam int TS  = 1 << CW;
  localparam int QAW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int QCW = $clog2(QUEUE_DEPTH + 1);

  typedef enum logic [5:0] {
    S_IDLE = 6'b000001,
    S_STK  = 6'b000010,
    S_FILL = 6'b000100,
    S_QLD  = 6'b001000,
    S_WALK = 6'b010000,
    S_WRD  = 6'b100000
  } state_e;

  state_e state_q, state_d;

  logic [3:0]     min_cs_q;
  logic [3:0]     root_q, root_d;
  logic [3:0]     cw_q, cw_d;
  logic [CW:0]    nfc_q, nfc_d;
  logic [CW:0]    wlim_q, wlim_d;
  logic [CW-1:0]  prev_q, prev_d;
  logic [7:0]     fc_q, fc_d;
  logic           fresh_q, fresh_d;
  logic           ended_q, ended_d;
  logic [CW:0]    depth_q, depth_d;
  logic [QAW-1:0] head_q, head_d;
  logic [QCW-1:0] cnt_q, cnt_d;
  logic [7:0]     brem_q, brem_d;
  logic [23:0]    buf_q, buf_d;
  logic [4:0]     bc_q, bc_d;
  logic [CW-1:0]  cur_q, cur_d;
  logic [CW-1:0]  incode_q, incode_d;
  logic           out_valid_q, out_valid_d;
  out_word_t      out_q, out_d;

  logic [7:0]     q_mem [QUEUE_DEPTH];
  logic [7:0]     q_rdata_q;
  logic           q_we;
  logic [QAW-1:0] q_waddr;

  logic [7:0]     stk_mem [TS];
  logic [7:0]     stk_rdata_q;
  logic           stk_we;
  logic [7:0]     stk_wdata;
  logic [CW-1:0]  stk_raddr;

  logic [CW+7:0]  tbl_mem [TS];
  logic [CW+7:0]  tbl_rdata_q;
  logic           tvalid_q;
  logic           tbl_we;

  logic [3:0]     root_new;
  logic [CW:0]    clr, clr_new, nfc_inc;
  logic [CW-1:0]  code_w, pre, nfc_idx;
  logic [7:0]     suf;
  logic [QAW:0]   pos_sum, pos;
  logic           in_fire;

  assign in_ready_o  = (state_q == S_IDLE) && (!out_valid_q || out_ready_i);
  assign in_fire     = in_valid_i && in_ready_o;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;
  assign pready      = 1'b1;
  assign prdata      = (paddr == REG_MIN_CODE_ADDR) ? {28'd0, min_cs_q} : 32'd0;

  assign root_new = (min_cs_q < ROOT_MIN) ? ROOT_MIN :
                    ((min_cs_q > ROOT_MAX) ? ROOT_MAX : min_cs_q);
  assign clr      = (CW+1)'(1) << root_q;
  assign clr_new  = (CW+1)'(1) << root_new;
  assign code_w   = buf_q[CW-1:0] & ~({CW{1'b1}} << cw_q);
  assign nfc_inc  = nfc_q + (CW+1)'(1);
  assign nfc_idx  = nfc_q[CW-1:0];
  assign pre      = tvalid_q ? tbl_rdata_q[CW+7:8] : '0;
  assign suf      = tvalid_q ? tbl_rdata_q[7:0] : 8'd0;
  assign pos_sum  = {1'b0, head_q} + (QAW+1)'(cnt_q);
  assign pos      = (pos_sum >= (QAW+1)'(QUEUE_DEPTH)) ?
                    pos_sum - (QAW+1)'(QUEUE_DEPTH) : pos_sum;
  assign q_waddr  = pos[QAW-1:0];
  assign stk_raddr = depth_q[CW-1:0] - CW'(1);

  always_comb begin
    state_d = state_q;
    root_d = root_q; cw_d = cw_q; nfc_d = nfc_q; wlim_d = wlim_q;
    prev_d = prev_q; fc_d = fc_q; fresh_d = fresh_q; ended_d = ended_q;
    depth_d = depth_q; head_d = head_q; cnt_d = cnt_q; brem_d = brem_q;
    buf_d = buf_q; bc_d = bc_q; cur_d = cur_q; incode_d = incode_q;
    out_valid_d = out_valid_q && !out_ready_i;
    out_d = out_q;
    q_we = 1'b0; stk_we = 1'b0; stk_wdata = fc_q; tbl_we = 1'b0;
    case (state_q)
      S_IDLE: begin
        if (in_fire) begin
          out_d.pixel = 8'd0;
          case (in_data_i.kind)
            KIND_START: begin
              root_d = root_new; cw_d = root_new + 4'd1;
              wlim_d = clr_new << 1; nfc_d = clr_new + (CW+1)'(2);
              depth_d = '0; fresh_d = 1'b1; prev_d = '0; fc_d = 8'd0;
              head_d = '0; cnt_d = '0; buf_d = '0; bc_d = '0; brem_d = 8'd0;
              ended_d = 1'b0;
              out_valid_d = 1'b1; out_d.status = ST_ACCEPT;
            end
            KIND_PUSH: begin
              out_valid_d = 1'b1; out_d.status = ST_ACCEPT;
              if (!ended_q) begin
                if (brem_q == 8'd0) begin
                  if (in_data_i.data_byte == 8'd0) ended_d = 1'b1;
                  else brem_d = in_data_i.data_byte;
                end else if (cnt_q >= QCW'(QUEUE_DEPTH)) begin
                  out_d.status = ST_REJECT;
                end else begin
                  q_we = 1'b1;
                  cnt_d = cnt_q + QCW'(1);
                  brem_d = brem_q - 8'd1;
                end
              end
            end
            KIND_PULL: begin
              if (depth_q != '0) begin
                depth_d = depth_q - (CW+1)'(1);
                state_d = S_STK;
              end else begin
                state_d = S_FILL;
              end
            end
            default: begin
              out_valid_d = 1'b1; out_d.status = ST_REJECT;
            end
          endcase
        end
      end
      S_STK: begin
        out_valid_d = 1'b1; out_d.status = ST_PIXEL; out_d.pixel = stk_rdata_q;
        state_d = S_IDLE;
      end
      S_FILL: begin
        out_d.pixel = 8'd0;
        if (bc_q <= 5'd16 && cnt_q != '0) begin
          state_d = S_QLD;
        end else if (bc_q < {1'b0, cw_q}) begin
          out_valid_d = 1'b1;
          out_d.status = (ended_q && cnt_q == '0) ? ST_RANOUT : ST_STARVED;
          state_d = S_IDLE;
        end else if ({1'b0, code_w} == clr + (CW+1)'(1)) begin
          out_valid_d = 1'b1; out_d.status = ST_END; state_d = S_IDLE;
        end else begin
          buf_d = buf_q >> cw_q;
          bc_d = bc_q - {1'b0, cw_q};
          if ({1'b0, code_w} == clr) begin
            cw_d = root_q + 4'd1; wlim_d = clr << 1; nfc_d = clr + (CW+1)'(2);
            depth_d = '0; fresh_d = 1'b1;
          end else if (fresh_q) begin
            fresh_d = 1'b0; fc_d = code_w[7:0]; prev_d = code_w;
            out_valid_d = 1'b1; out_d.status = ST_PIXEL; out_d.pixel = code_w[7:0];
            state_d = S_IDLE;
          end else begin
            incode_d = code_w;
            if ({1'b0, code_w} >= nfc_q) begin
              stk_we = 1'b1; stk_wdata = fc_q;
              depth_d = depth_q + (CW+1)'(1);
              cur_d = prev_q;
            end else begin
              cur_d = code_w;
            end
            state_d = S_WALK;
          end
        end
      end
      S_QLD: begin
        buf_d = buf_q | ({16'd0, q_rdata_q} << bc_q);
        bc_d = bc_q + 5'd8;
        head_d = (head_q == QAW'(QUEUE_DEPTH - 1)) ? '0 : head_q + QAW'(1);
        cnt_d = cnt_q - QCW'(1);
        state_d = S_FILL;
      end
      S_WALK: begin
        if ({1'b0, cur_q} >= clr) begin
          state_d = S_WRD;
        end else begin
          fc_d = cur_q[7:0];
          if (nfc_q < (CW+1)'(TS)) begin
            tbl_we = 1'b1;
            nfc_d = nfc_inc;
            if (nfc_inc >= wlim_q && wlim_q < (CW+1)'(TS)) begin
              wlim_d = wlim_q << 1; cw_d = cw_q + 4'd1;
            end
          end
          prev_d = incode_q;
          out_valid_d = 1'b1; out_d.status = ST_PIXEL; out_d.pixel = cur_q[7:0];
          state_d = S_IDLE;
        end
      end
      S_WRD: begin
        if (depth_q >= (CW+1)'(TS - 1) || pre == cur_q) begin
          depth_d = '0;
          out_valid_d = 1'b1; out_d.status = ST_CIRCULAR; out_d.pixel = 8'd0;
          state_d = S_IDLE;
        end else begin
          stk_we = 1'b1; stk_wdata = suf;
          depth_d = depth_q + (CW+1)'(1);
          cur_d = pre;
          state_d = S_WALK;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      min_cs_q <= MIN_CODE_RESET;
      root_q <= ROOT_MAX; cw_q <= ROOT_MAX + 4'd1;
      wlim_q <= (CW+1)'(512); nfc_q <= (CW+1)'(258);
      prev_q <= '0; fc_q <= 8'd0; fresh_q <= 1'b1; ended_q <= 1'b0;
      depth_q <= '0; head_q <= '0; cnt_q <= '0; brem_q <= 8'd0;
      buf_q <= '0; bc_q <= '0; cur_q <= '0; incode_q <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (psel && penable && pwrite && pready && paddr == REG_MIN_CODE_ADDR) begin
        min_cs_q <= pwdata[3:0];
      end
      root_q <= root_d; cw_q <= cw_d; wlim_q <= wlim_d; nfc_q <= nfc_d;
      prev_q <= prev_d; fc_q <= fc_d; fresh_q <= fresh_d; ended_q <= ended_d;
      depth_q <= depth_d; head_q <= head_d; cnt_q <= cnt_d; brem_q <= brem_d;
      buf_q <= buf_d; bc_q <= bc_d; cur_q <= cur_d; incode_q <= incode_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q <= out_d;
    tvalid_q <= ({1'b0, cur_q} >= clr + (CW+1)'(2)) && ({1'b0, cur_q} < nfc_q);
  end

  always_ff @(posedge clk_i) begin
    if (q_we) q_mem[q_waddr] <= in_data_i.data_byte;
    q_rdata_q <= q_mem[head_q];
  end

  always_ff @(posedge clk_i) begin
    if (stk_we) stk_mem[depth_q[CW-1:0]] <= stk_wdata;
    stk_rdata_q <= stk_mem[stk_raddr];
  end

  always_ff @(posedge clk_i) begin
    if (tbl_we) tbl_mem[nfc_idx] <= {prev_q, cur_q[7:0]};
    tbl_rdata_q <= tbl_mem[cur_q];
  end

endmodule
`default_nettype wire

// ----- src/gld_checker.sv -----
`default_nettype none
module gld_checker import gld_pkg::*; (
  input wire logic      clk_i,
  input wire logic      rst_ni,
  input wire logic      in_valid_i,
  input wire logic      in_ready_o,
  input wire in_word_t  in_data_i,
  input wire logic      out_valid_o,
  input wire logic      out_ready_i,
  input wire out_word_t out_data_o
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_data_o))
    else $error("result word changed while stalled");

  a_one_in_flight: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |-> !out_valid_o || out_ready_i)
    else $error("word taken while a result is still pending");

  a_quick_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o && in_data_i.kind != KIND_PULL |=>
      out_valid_o && (out_data_o.status == ST_ACCEPT || out_data_o.status == ST_REJECT))
    else $error("non-pull word gave no immediate accept or reject");

  a_pixel_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.status != ST_PIXEL |-> out_data_o.pixel == 8'd0)
    else $error("pixel nonzero on a non-pixel result");

endmodule

bind gif_lzw_decoder_core gld_checker u_gld_checker (.*);
`default_nettype wire

// ----- test/tb_gif_lzw_decoder_core.sv -----
`default_nettype none
module tb_gif_lzw_decoder_core;
  import gld_pkg::*;

  localparam int TBL = 4096;
  localparam int QDEPTH = 16;

  class pixel_scoreboard;
    bit [11:0] prefix_tbl[TBL];
    bit [7:0] suffix_tbl[TBL];
    bit [7:0] pix_stack[TBL];
    bit [7:0] byte_q[QDEPTH];
    int unsigned stack_depth, q_head, q_count, bit_count, block_left;
    int unsigned code_width, next_free, width_limit, prev_code, first_char, root;
    bit [31:0] bit_buf;
    bit fresh, ended;
    bit [3:0] min_code;
    out_word_t expected_words[$];
    int errors;

    function new();
      min_code = MIN_CODE_RESET;
      errors = 0;
      start_image();
    endfunction

    function void init_tables();
      int unsigned clr;
      clr = 1 << root;
      for (int i = 0; i < TBL; i++) begin
        prefix_tbl[i] = '0;
        suffix_tbl[i] = (i < clr) ? i[7:0] : 8'd0;
      end
      code_width = root + 1;
      width_limit = clr << 1;
      next_free = clr + 2;
      stack_depth = 0;
    endfunction

    function void start_image();
      root = (min_code < ROOT_MIN) ? ROOT_MIN : ((min_code > ROOT_MAX) ? ROOT_MAX : min_code);
      init_tables();
      fresh = 1;
      prev_code = 0;
      first_char = 0;
      q_head = 0;
      q_count = 0;
      bit_buf = 0;
      bit_count = 0;
      block_left = 0;
      ended = 0;
    endfunction

    function logic [2:0] push_byte(bit [7:0] b);
      if (ended) return ST_ACCEPT;
      if (block_left == 0) begin
        if (b == 0) ended = 1;
        else block_left = b;
        return ST_ACCEPT;
      end
      if (q_count >= QDEPTH) return ST_REJECT;
      byte_q[(q_head + q_count) % QDEPTH] = b;
      q_count++;
      block_left--;
      return ST_ACCEPT;
    endfunction

    function logic [2:0] pull_pixel(output bit [7:0] pix);
      int unsigned code, incode, clr;
      pix = 0;
      clr = 1 << root;
      if (stack_depth > 0) begin
        stack_depth--;
        pix = pix_stack[stack_depth % TBL];
        return ST_PIXEL;
      end
      forever begin
        while (bit_count <= 16 && q_count > 0) begin
          bit_buf |= 32'(byte_q[q_head]) << bit_count;
          q_head = (q_head + 1) % QDEPTH;
          q_count--;
          bit_count += 8;
        end
        bit_buf &= 32'hFF_FFFF;
        if (bit_count < code_width)
          return (ended && q_count == 0) ? ST_RANOUT : ST_STARVED;
        code = bit_buf & ((1 << code_width) - 1);
        if (code == clr + 1) return ST_END;
        bit_buf >>= code_width;
        bit_count -= code_width;
        if (code == clr) begin
          init_tables();
          fresh = 1;
          continue;
        end
        if (fresh) begin
          fresh = 0;
          first_char = code;
          prev_code = code;
          pix = code[7:0];
          return ST_PIXEL;
        end
        incode = code;
        if (code >= next_free) begin
          pix_stack[stack_depth++] = first_char[7:0];
          code = prev_code;
        end
        while (code >= clr) begin
          if (stack_depth >= TBL - 1 || prefix_tbl[code] == code) begin
            stack_depth = 0;
            return ST_CIRCULAR;
          end
          pix_stack[stack_depth++] = suffix_tbl[code];
          code = prefix_tbl[code];
        end
        first_char = suffix_tbl[code];
        pix_stack[stack_depth++] = first_char[7:0];
        if (next_free < TBL) begin
          prefix_tbl[next_free] = prev_code[11:0];
          suffix_tbl[next_free] = first_char[7:0];
          next_free++;
          if (next_free >= width_limit && width_limit < TBL) begin
            width_limit <<= 1;
            code_width++;
          end
        end
        prev_code = incode;
        stack_depth--;
        pix = pix_stack[stack_depth];
        return ST_PIXEL;
      end
    endfunction

    function logic [2:0] note_word(in_word_t w);
      out_word_t r;
      bit [7:0] pix;
      pix = 0;
      case (w.kind)
        KIND_START: begin
          start_image();
          r.status = ST_ACCEPT;
        end
        KIND_PUSH: r.status = push_byte(w.data_byte);
        KIND_PULL: r.status = pull_pixel(pix);
        default: r.status = ST_REJECT;
      endcase
      r.pixel = (r.status == ST_PIXEL) ? pix : 8'd0;
      expected_words.push_back(r);
      return r.status;
    endfunction

    function void check_word(out_word_t got);
      out_word_t exp_w;
      if (expected_words.size() == 0) begin
        $error("unexpected word status=%0d pixel=%0d", got.status, got.pixel);
        errors++;
        return;
      end
      exp_w = expected_words.pop_front();
      if (got.status !== exp_w.status) begin
        $error("status expected %0d actual %0d", exp_w.status, got.status);
        errors++;
      end
      if (got.pixel !== exp_w.pixel) begin
        $error("pixel expected %0d actual %0d", exp_w.pixel, got.pixel);
        errors++;
      end
    endfunction
  endclass

  logic clk_i, rst_ni;
  logic in_valid_i, in_ready_o, out_valid_o, out_ready_i;
  in_word_t in_data_i;
  out_word_t out_data_o;
  logic psel, penable, pwrite, pready;
  logic [2:0] paddr;
  logic [31:0] pwdata, prdata;

  gif_lzw_decoder_core DUT (
    .clk_i(clk_i), .rst_ni(rst_ni),
    .in_valid_i(in_valid_i), .in_ready_o(in_ready_o), .in_data_i(in_data_i),
    .out_valid_o(out_valid_o), .out_ready_i(out_ready_i), .out_data_o(out_data_o),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  pixel_scoreboard sb;
  int words_sent;
  int holdoff_left;
  bit holdoff_go;
  bit quiet;

  always begin
    clk_i = 1'b0;
    #10;
    clk_i = 1'b1;
    #10;
  end

  initial begin
    #(20 * 4_000_000);
    $display("tb_gif_lzw_decoder_core failed");
    $finish;
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) sb.check_word(out_data_o);
    if (holdoff_go) begin
      holdoff_go <= 1'b0;
      holdoff_left <= 400;
      out_ready_i <= 1'b0;
    end else if (holdoff_left > 0) begin
      holdoff_left <= holdoff_left - 1;
      out_ready_i <= 1'b0;
    end else begin
      out_ready_i <= quiet || ($urandom_range(99) >= 18);
    end
  end

  task automatic send(logic [1:0] kind, logic [7:0] b, output logic [2:0] st);
    in_word_t w;
    w.kind = kind;
    w.data_byte = b;
    if (!quiet && $urandom_range(99) < 18) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i <= w;
    do @(posedge clk_i); while (!in_ready_o);
    st = sb.note_word(w);
    words_sent++;
    quiet = (words_sent > 700 && words_sent < 900);
  endtask

  task automatic drain();
    in_valid_i <= 1'b0;
    while (sb.expected_words.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
  endtask

  task automatic write_min_code(logic [3:0] v);
    drain();
    psel <= 1'b1;
    pwrite <= 1'b1;
    penable <= 1'b0;
    paddr <= REG_MIN_CODE_ADDR;
    pwdata <= {28'd0, v};
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel <= 1'b0;
    penable <= 1'b0;
    sb.min_code = v;
  endtask

  // pack codes lsb-first, tracking width as the decoder grows it, then frame
  function automatic void encode(int unsigned codes[$], int unsigned root, bit term,
                                 int max_blk, ref logic [7:0] bytes[$]);
    logic [7:0] raw[$];
    logic [63:0] acc;
    int n, w, len;
    int unsigned clr, nf, lim;
    bit fr;
    clr = 1 << root;
    w = root + 1;
    nf = clr + 2;
    lim = clr << 1;
    fr = 1;
    acc = 0;
    n = 0;
    foreach (codes[i]) begin
      acc |= 64'(codes[i]) << n;
      n += w;
      while (n >= 8) begin
        raw.push_back(acc[7:0]);
        acc >>= 8;
        n -= 8;
      end
      if (codes[i] == clr) begin
        w = root + 1;
        nf = clr + 2;
        lim = clr << 1;
        fr = 1;
      end else if (fr) begin
        fr = 0;
      end else if (nf < TBL) begin
        nf++;
        if (nf >= lim && lim < TBL) begin
          lim <<= 1;
          w++;
        end
      end
    end
    if (n > 0) raw.push_back(acc[7:0]);
    while (raw.size() > 0) begin
      len = $urandom_range(1, max_blk);
      if (len > raw.size()) len = raw.size();
      bytes.push_back(len[7:0]);
      repeat (len) bytes.push_back(raw.pop_front());
    end
    if (term) bytes.push_back(8'd0);
  endfunction

  task automatic pull_some(int cnt, output logic [2:0] st);
    st = ST_PIXEL;
    repeat (cnt) send(KIND_PULL, 8'd0, st);
  endtask

  task automatic run_image(logic [3:0] cfg, int unsigned codes[$], bit term, int max_blk,
                           int max_pulls);
    logic [7:0] bytes[$];
    logic [2:0] st;
    int unsigned root;
    int k;
    bit stuck;
    stuck = 1'b0;
    if (cfg != sb.min_code) write_min_code(cfg);
    send(KIND_START, 8'($urandom), st);
    root = (cfg < ROOT_MIN) ? ROOT_MIN : ((cfg > ROOT_MAX) ? ROOT_MAX : cfg);
    encode(codes, root, term, max_blk, bytes);
    // an end code at the head of a full queue blocks pushes for good
    foreach (bytes[i]) begin
      if (!stuck) begin
        send(KIND_PUSH, bytes[i], st);
        while (st == ST_REJECT && !stuck) begin
          pull_some($urandom_range(1, 3), st);
          stuck = (st == ST_END);
          if (!stuck) send(KIND_PUSH, bytes[i], st);
        end
        if (!stuck && $urandom_range(99) < 40) pull_some($urandom_range(1, 3), st);
      end
    end
    k = 0;
    do begin
      send(KIND_PULL, 8'd0, st);
      k++;
    end while (st != ST_END && st != ST_RANOUT && st != ST_STARVED && k < max_pulls);
  endtask

  function automatic void random_codes(int unsigned root, int cnt, bit with_end,
                                       ref int unsigned codes[$]);
    int unsigned clr, nf, w, lim, c;
    bit fr;
    clr = 1 << root;
    codes.push_back(clr);
    nf = clr + 2;
    w = root + 1;
    lim = clr << 1;
    fr = 1;
    repeat (cnt) begin
      if (fr) begin
        c = ($urandom_range(99) < 92) ? $urandom_range(clr - 1) : $urandom_range((1 << w) - 1);
        if (c == clr + 1) c = 0;
      end else if ($urandom_range(99) < 4) begin
        c = clr;
      end else begin
        c = $urandom_range(nf);
        if (c == clr + 1) c = $urandom_range(clr - 1);
      end
      codes.push_back(c);
      if (c == clr) begin
        nf = clr + 2;
        w = root + 1;
        lim = clr << 1;
        fr = 1;
      end else if (fr) begin
        fr = 0;
      end else if (nf < TBL) begin
        nf++;
        if (nf >= lim && lim < TBL) begin
          lim <<= 1;
          w++;
        end
      end
    end
    if (with_end) codes.push_back(clr + 1);
  endfunction

  initial begin
    int unsigned codes[$];
    logic [2:0] st;
    logic [3:0] cfg;
    int r;
    rst_ni = 1'b0;
    in_valid_i = 1'b0;
    in_data_i = '0;
    out_ready_i = 1'b0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    holdoff_left = 0;
    holdoff_go = 1'b0;
    quiet = 1'b0;
    words_sent = 0;
    sb = new();
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // unused kind, pull on empty, bytes after terminator
    send(2'd3, 8'hFF, st);
    send(KIND_PULL, 8'd0, st);
    send(KIND_PUSH, 8'd0, st);
    send(KIND_PUSH, 8'hA5, st);
    send(KIND_PULL, 8'd0, st);
    // kwkwk, double clear, non-root first code, self-prefixed entry
    codes = '{256, 256, 65, 258, 300, 256, 5, 259, 7, 259, 257};
    run_image(4'd8, codes, 1, 255, 20);
    codes = '{4, 3, 0, 6, 7, 4, 1, 2, 5};
    run_image(4'd2, codes, 1, 1, 20);
    codes = '{8, 7, 9};
    run_image(4'd0, codes, 1, 3, 10);
    codes = '{256, 255, 0, 258};
    run_image(4'd15, codes, 0, 2, 10);

    while (words_sent < 1550) begin
      r = $urandom_range(99);
      cfg = (r < 25) ? 4'd2 : (r < 45) ? 4'd8 : (r < 52) ? 4'($urandom_range(15))
            : 4'($urandom_range(2, 8));
      codes.delete();
      random_codes((cfg < 2) ? 2 : (cfg > 8) ? 8 : cfg, $urandom_range(10, 70),
                   $urandom_range(99) < 85, codes);
      if ($urandom_range(99) < 8) foreach (codes[i]) codes[i] = $urandom_range(511);
      if (words_sent > 300 && words_sent < 500 && holdoff_left == 0 && !holdoff_go)
        holdoff_go = 1'b1;
      run_image(cfg, codes, $urandom_range(99) < 90, $urandom_range(1, 20), 120);
      if ($urandom_range(99) < 10) send(2'd3, 8'($urandom), st);
      if ($urandom_range(99) < 10) send(KIND_PUSH, 8'($urandom), st);
    end

    drain();
    repeat (20) @(posedge clk_i);
    if (sb.errors == 0 && sb.expected_words.size() == 0) begin
      $display("tb_gif_lzw_decoder_core passed");
    end else begin
      $display("tb_gif_lzw_decoder_core failed");
    end
    $finish;
  end

endmodule
`default_nettype wire

// ----- gif_lzw_decoder_core.f -----
src/gld_pkg.sv
src/gif_lzw_decoder_core.sv
src/gld_checker.sv
test/tb_gif_lzw_decoder_core.sv
